### rtl/core/luhn_pkg.sv
// Types and constants shared by the Luhn card number classifier.
// Depends on nothing.
`default_nettype none

package luhn_pkg;

  localparam int NumWidth  = 54;
  localparam int NumDigits = 17;
  localparam int ProdWidth = 60;

  localparam logic [4:0] LenVisaShort = 5'd13;
  localparam logic [4:0] LenAmex      = 5'd15;
  localparam logic [4:0] LenLong      = 5'd16;

  localparam logic [3:0] LeadVisa   = 4'd4;
  localparam logic [3:0] LeadMc     = 4'd5;
  localparam logic [3:0] LeadAmex   = 4'd3;
  localparam logic [3:0] SecMcLow   = 4'd1;
  localparam logic [3:0] SecMcHigh  = 4'd5;
  localparam logic [3:0] SecAmexLow = 4'd4;
  localparam logic [3:0] SecAmexHi  = 4'd7;

  typedef enum logic [1:0] {
    KIND_INVALID = 2'd0,
    KIND_VISA    = 2'd1,
    KIND_MC      = 2'd2,
    KIND_AMEX    = 2'd3
  } card_kind_t;

  typedef struct packed {
    logic [NumWidth-1:0] rem;
    logic [3:0]          sum;
    logic [4:0]          len;
    logic [3:0]          lead;
    logic [3:0]          second;
  } luhn_tok_t;

  function automatic logic [ProdWidth-1:0] pow10(input int k);
    logic [ProdWidth-1:0] p;
    p = ProdWidth'(1);
    for (int i = 0; i < k; i++) begin
      p = p * ProdWidth'(10);
    end
    return p;
  endfunction

endpackage

`default_nettype wire

### rtl/core/luhn_cell.sv
// One digit cell of the chain: peels one decimal digit off the remainder,
// folds it into the Luhn sum and the length and prefix record. Uses luhn_pkg.
`default_nettype none

module luhn_cell
  import luhn_pkg::*;
#(
  parameter int POS    = 0,
  parameter bit IN_SUM = 1'b1
) (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      en,
  input  wire logic      in_valid,
  input  wire luhn_tok_t in_tok,
  output logic           out_valid,
  output luhn_tok_t      out_tok
);

  localparam logic [ProdWidth-1:0] Step   = pow10(POS);
  localparam bit                   Odd    = (POS % 2) == 1;
  localparam logic [4:0]           LenHere = 5'(POS + 1);
  localparam logic [4:0]           LenSec  = 5'(POS + 2);

  luhn_tok_t tok_next;

  always_comb begin
    logic [3:0]           d;
    logic [ProdWidth-1:0] sub;
    logic [ProdWidth-1:0] wide;
    logic [4:0]           dbl;
    logic [4:0]           c;
    logic [4:0]           s;
    wide = {{(ProdWidth-NumWidth){1'b0}}, in_tok.rem};
    d    = 4'd0;
    sub  = '0;
    for (int m = 1; m <= 9; m++) begin
      if (wide >= ProdWidth'(m) * Step) begin
        d   = d + 4'd1;
        sub = ProdWidth'(m) * Step;
      end
    end
    dbl = {d, 1'b0};
    if (!IN_SUM) begin
      c = 5'd0;
    end else if (Odd) begin
      c = (dbl >= 5'd10) ? dbl - 5'd9 : dbl;
    end else begin
      c = {1'b0, d};
    end
    s = {1'b0, in_tok.sum} + c;
    if (s >= 5'd10) begin
      s = s - 5'd10;
    end
    tok_next     = in_tok;
    tok_next.rem = in_tok.rem - sub[NumWidth-1:0];
    tok_next.sum = s[3:0];
    if (in_tok.len == 5'd0 && d != 4'd0) begin
      tok_next.len  = LenHere;
      tok_next.lead = d;
    end else if (in_tok.len == LenSec) begin
      tok_next.second = d;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_tok <= tok_next;
    end
  end

endmodule

`default_nettype wire

### rtl/core/luhn_class.sv
// Final checksum test and card kind decode from the length and prefix.
// Uses luhn_pkg.
`default_nettype none

module luhn_class
  import luhn_pkg::*;
(
  input  wire luhn_tok_t tok,
  output card_kind_t     kind,
  output logic           ok
);

  always_comb begin
    ok   = (tok.sum == 4'd0);
    kind = KIND_INVALID;
    if (ok) begin
      priority if ((tok.len == LenVisaShort || tok.len == LenLong) && tok.lead == LeadVisa) begin
        kind = KIND_VISA;
      end else if (tok.len == LenLong && tok.lead == LeadMc &&
                   tok.second >= SecMcLow && tok.second <= SecMcHigh) begin
        kind = KIND_MC;
      end else if (tok.len == LenAmex && tok.lead == LeadAmex &&
                   (tok.second == SecAmexLow || tok.second == SecAmexHi)) begin
        kind = KIND_AMEX;
      end
    end
  end

endmodule

`default_nettype wire

### rtl/core/card_number_luhn_classify.sv
// Top level of the Luhn card number classifier: chain of digit cells,
// class decode and output register. Uses luhn_pkg, luhn_cell, luhn_class.
//
//   channel   data                       handshake
//   card      card_number                card_valid / card_stall
//   result    card_kind, checksum_ok     result_valid / result_stall
//
// One number enters per cycle while card_stall is low; it passes through the
// cell chain (17 cells, one per decimal digit, most significant first)
// and then through the output register.
// Reset clears every valid bit; payload registers are left as they are.
// A stalled valid result freezes the whole chain and raises card_stall.
`default_nettype none

module card_number_luhn_classify
  import luhn_pkg::*;
#(
  parameter int DIGIT_PAIRS = 8
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic [NumWidth-1:0] card_number,
  input  wire logic                card_valid,
  output logic                     card_stall,
  output logic [1:0]               card_kind,
  output logic                     checksum_ok,
  output logic                     result_valid,
  input  wire logic                result_stall
);

  logic       adv;
  logic       link_valid [NumDigits+1];
  luhn_tok_t  link_tok   [NumDigits+1];
  card_kind_t kind_c;
  logic       ok_c;

  assign adv        = !(result_valid && result_stall);
  assign card_stall = !adv;

  assign link_valid[0] = card_valid;
  always_comb begin
    link_tok[0]     = '0;
    link_tok[0].rem = card_number;
  end

  for (genvar i = 0; i < NumDigits; i++) begin : g_cell
    luhn_cell #(
      .POS    (NumDigits - 1 - i),
      .IN_SUM ((NumDigits - 1 - i) < 2 * DIGIT_PAIRS)
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .en        (adv),
      .in_valid  (link_valid[i]),
      .in_tok    (link_tok[i]),
      .out_valid (link_valid[i+1]),
      .out_tok   (link_tok[i+1])
    );
  end

  luhn_class u_class (
    .tok  (link_tok[NumDigits]),
    .kind (kind_c),
    .ok   (ok_c)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (adv) begin
      result_valid <= link_valid[NumDigits];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      card_kind   <= kind_c;
      checksum_ok <= ok_c;
    end
  end

endmodule

`default_nettype wire

### rtl/core/luhn_check.sv
// Port checker for the Luhn card number classifier, bound to the top level.
// Depends on luhn_pkg and card_number_luhn_classify.
`default_nettype none

module luhn_check
  import luhn_pkg::*;
(
  input wire logic                clk,
  input wire logic                rst,
  input wire logic                card_stall,
  input wire logic [1:0]          card_kind,
  input wire logic                checksum_ok,
  input wire logic                result_valid,
  input wire logic                result_stall
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid && $stable(card_kind) &&
    $stable(checksum_ok))
    else $error("stalled result changed");

  a_kind_ok: assert property (@(posedge clk) disable iff (rst)
    result_valid && card_kind != KIND_INVALID |-> checksum_ok)
    else $error("card kind given without a passing checksum");

  a_free: assert property (@(posedge clk) disable iff (rst)
    !result_stall |-> !card_stall)
    else $error("input stalled while output is free");

  a_block: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |-> card_stall)
    else $error("input taken while result is held");

  a_reset: assert property (@(posedge clk)
    rst |=> !result_valid)
    else $error("result valid straight after reset");

endmodule

bind card_number_luhn_classify luhn_check u_luhn_check (.*);

`default_nettype wire
